// File: rtl/c3ms_pkg.sv
// Shared types and constants of the 3x3 mean / Laplace / sharpen filter.
// Holds the item payloads, the front-to-back queue entry and the register map.
// No dependencies.
package c3ms_pkg;

  localparam int DEF_MAX_WIDTH      = 1024;
  localparam int DEF_MAX_HEIGHT     = 4096;
  localparam int DEF_GAIN_FRAC_BITS = 8;

  localparam int PIX_W    = 8;
  localparam int MODE_W   = 2;
  localparam int GAIN_W   = 12;
  localparam int WREG_W   = 11;
  localparam int HREG_W   = 13;
  localparam int SUM9_W   = 12;
  localparam int SUM4_W   = 10;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  localparam int MQ_DEPTH  = 4;
  localparam int RES_DEPTH = 8;

  // floor(x/9) == (x * DIV9_MULT) >> DIV9_SHIFT for every x below 2296
  localparam int DIV9_MULT  = 116509;
  localparam int DIV9_MULT_W = 17;
  localparam int DIV9_SHIFT = 20;

  localparam logic [1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [1:0] REG_SHARPEN_GAIN = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

  localparam logic [MODE_W-1:0] MODE_BOX     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LAPLACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd2;

  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_DRAIN = 1'b1;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered_value;
    logic             frame_last;
  } out_item_t;

  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } tap_mask_t;

  typedef struct packed {
    logic             wr;
    logic [PIX_W-1:0] pixel;
    logic             emit;
    tap_mask_t        mask;
    logic             last;
  } mq_entry_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

endpackage

// File: rtl/c3ms_fifo.sv
// Small register-based queue of a generic payload type.
// Used between front and back and as the result queue. No dependencies.
module c3ms_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  T                           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output T                           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH+1);

  T              mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] cnt_q;
  logic          push_ok, pop_ok;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_ok && pop_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/c3ms_front.sv
// Front end: accepts pixel and drain items, tracks the backlog and output
// position, decides whether a result is due and queues the work. Uses c3ms_pkg.
module c3ms_front #(
  parameter int MAX_WIDTH  = c3ms_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = c3ms_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            restart_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] h_i,
  input  logic                            push_i,
  input  c3ms_pkg::in_item_t              item_i,
  input  logic                            mq_full_i,
  output logic                            mq_push_o,
  output c3ms_pkg::mq_entry_t             mq_entry_o
);

  import c3ms_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int BW = $clog2(MAX_WIDTH+3) + 1;

  logic [BW-1:0] backlog_q, backlog_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [RW-1:0] out_row_q, out_row_d;

  logic          take, is_pix, emit, last_col, last_row, penult_row;
  logic [WW:0]   col_p1;
  logic [HW:0]   row_p1, row_p2;
  logic [BW-1:0] bl_new, need, w_x;

  always_comb begin
    take       = push_i && !mq_full_i;
    is_pix     = (item_i.action == ACTION_PIXEL);
    col_p1     = (WW+1)'(out_col_q) + 1'b1;
    row_p1     = (HW+1)'(out_row_q) + 1'b1;
    row_p2     = (HW+1)'(out_row_q) + 2'd2;
    last_col   = (col_p1 == (WW+1)'(w_i));
    last_row   = (row_p1 == (HW+1)'(h_i));
    penult_row = (row_p2 == (HW+1)'(h_i));
    w_x        = BW'(w_i);
    // results wait for the pixel one row and one pixel on, or the frame end
    if (last_row) begin
      need = w_x - BW'(out_col_q);
    end else if (penult_row && last_col) begin
      need = w_x + 1'b1;
    end else begin
      need = w_x + 2'd2;
    end
    bl_new = backlog_q + BW'(is_pix);
    emit   = take && (bl_new >= need);

    backlog_d = backlog_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (take) begin
      backlog_d = bl_new - BW'(emit);
    end
    if (emit) begin
      if (last_col) begin
        out_col_d = '0;
        out_row_d = last_row ? '0 : out_row_q + 1'b1;
      end else begin
        out_col_d = out_col_q + 1'b1;
      end
    end
    if (restart_i) begin
      backlog_d = '0;
      out_col_d = '0;
      out_row_d = '0;
    end

    mq_push_o             = take && (is_pix || emit);
    mq_entry_o.wr         = is_pix;
    mq_entry_o.pixel      = item_i.pixel_value;
    mq_entry_o.emit       = emit;
    mq_entry_o.mask.up    = (out_row_q != '0);
    mq_entry_o.mask.down  = !last_row;
    mq_entry_o.mask.left  = (out_col_q != '0);
    mq_entry_o.mask.right = !last_col;
    mq_entry_o.last       = last_row && last_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backlog_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      backlog_q <= backlog_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> (backlog_q == '0) && (out_col_q == '0) && (out_row_q == '0))
    else $error("front: restart did not clear position");

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WW+1)'(out_col_q) < (WW+1)'(w_i))
    else $error("front: output column beyond row width");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (HW+1)'(out_row_q) < (HW+1)'(h_i))
    else $error("front: output row beyond frame height");

endmodule

// File: rtl/c3ms_back.sv
// Back end: pixel rings, 3x3 window and filter arithmetic, four stages deep.
// Takes entries from the front queue, pushes results to the result queue.
// Uses c3ms_pkg.
module c3ms_back #(
  parameter int MAX_WIDTH      = c3ms_pkg::DEF_MAX_WIDTH,
  parameter int GAIN_FRAC_BITS = c3ms_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     restart_i,
  input  c3ms_pkg::cfg_t                           cfg_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]           w_i,
  input  c3ms_pkg::mq_entry_t                      mq_entry_i,
  input  logic                                     mq_empty_i,
  output logic                                     mq_pop_o,
  input  logic [$clog2(c3ms_pkg::RES_DEPTH+1)-1:0] res_count_i,
  output logic                                     res_push_o,
  output c3ms_pkg::out_item_t                      res_item_o
);

  import c3ms_pkg::*;

  localparam int AW   = $clog2(2*MAX_WIDTH+4);
  localparam int RING = 2**AW;
  localparam int GFB  = GAIN_FRAC_BITS;
  localparam int OGW  = ((GFB > GAIN_W) ? GFB : GAIN_W) + 1;
  localparam int P1W  = OGW + PIX_W;
  localparam int P2W  = GAIN_W + SUM4_W;
  localparam int NUMW = ((P1W + 2 > P2W) ? P1W + 2 : P2W) + 1;
  localparam int Q9W  = SUM9_W + DIV9_MULT_W;
  localparam int LAPW = PIX_W + 3;
  localparam int KW   = $clog2(RES_DEPTH+1) + 1;

  logic [PIX_W-1:0] mem_up  [RING];
  logic [PIX_W-1:0] mem_mid [RING];
  logic [PIX_W-1:0] mem_dn  [RING];

  logic [AW-1:0] wr_slot_q, out_slot_q, w_a;
  logic [AW-1:0] ad_up_c, ad_up_r, ad_mid_c, ad_mid_r, ad_dn_c, ad_dn_r;
  logic [KW-1:0] inflight;
  logic          mem_we;

  // stage a: addressed
  logic          a_vld_q;
  logic [AW-1:0] a_base_q;
  tap_mask_t     a_mask_q;
  logic          a_last_q;
  // stage b: ring data back
  logic             b_vld_q, b_last_q;
  tap_mask_t        b_mask_q;
  logic [PIX_W-1:0] up_c_q, up_r_q, mid_c_q, mid_r_q, dn_c_q, dn_r_q;
  logic [PIX_W-1:0] lc_up_q, lc_mid_q, lc_dn_q;
  // stage c: sums
  logic              c_vld_q, c_last_q;
  logic [SUM9_W-1:0] c_sum9_q, sum9;
  logic [SUM4_W-1:0] c_sum4_q, sum4;
  logic [PIX_W-1:0]  c_ctr_q;
  logic [PIX_W-1:0]  t [9];
  // stage d: products
  logic             d_vld_q, d_last_q;
  logic [P1W-1:0]   d_p1_q;
  logic [P2W-1:0]   d_p2_q;
  logic [PIX_W-1:0] d_q9_q, d_ctr_q;
  logic [LAPW-1:0]  d_lap_q;
  logic [OGW-1:0]   one_g;
  logic [Q9W-1:0]   q9;
  logic [NUMW-1:0]  num, num_sh;
  logic [PIX_W-1:0] res;

  assign inflight = KW'(a_vld_q) + KW'(b_vld_q) + KW'(c_vld_q) + KW'(d_vld_q);
  assign mq_pop_o = !mq_empty_i && ((KW'(res_count_i) + inflight) < KW'(RES_DEPTH));
  assign mem_we   = mq_pop_o && mq_entry_i.wr;
  assign w_a      = AW'(w_i);

  assign ad_mid_c = a_base_q;
  assign ad_mid_r = a_base_q + 1'b1;
  assign ad_up_c  = a_base_q - w_a;
  assign ad_up_r  = ad_mid_r - w_a;
  assign ad_dn_c  = a_base_q + w_a;
  assign ad_dn_r  = ad_mid_r + w_a;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_up[wr_slot_q] <= mq_entry_i.pixel;
    end
    if (a_vld_q) begin
      up_c_q <= mem_up[ad_up_c];
      up_r_q <= mem_up[ad_up_r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_mid[wr_slot_q] <= mq_entry_i.pixel;
    end
    if (a_vld_q) begin
      mid_c_q <= mem_mid[ad_mid_c];
      mid_r_q <= mem_mid[ad_mid_r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_dn[wr_slot_q] <= mq_entry_i.pixel;
    end
    if (a_vld_q) begin
      dn_c_q <= mem_dn[ad_dn_c];
      dn_r_q <= mem_dn[ad_dn_r];
    end
  end

  // window: left column is the centre column of the previous result
  always_comb begin
    t[0] = (b_mask_q.up && b_mask_q.left)    ? lc_up_q  : '0;
    t[1] =  b_mask_q.up                      ? up_c_q   : '0;
    t[2] = (b_mask_q.up && b_mask_q.right)   ? up_r_q   : '0;
    t[3] =  b_mask_q.left                    ? lc_mid_q : '0;
    t[4] =  mid_c_q;
    t[5] =  b_mask_q.right                   ? mid_r_q  : '0;
    t[6] = (b_mask_q.down && b_mask_q.left)  ? lc_dn_q  : '0;
    t[7] =  b_mask_q.down                    ? dn_c_q   : '0;
    t[8] = (b_mask_q.down && b_mask_q.right) ? dn_r_q   : '0;
    sum9 = '0;
    for (int i = 0; i < 9; i++) begin
      sum9 = sum9 + SUM9_W'(t[i]);
    end
    sum4 = SUM4_W'(t[1]) + SUM4_W'(t[3]) + SUM4_W'(t[5]) + SUM4_W'(t[7]);
  end

  assign one_g = (OGW'(1) << GFB) + OGW'(cfg_i.gain);
  assign q9    = Q9W'(c_sum9_q) * Q9W'(DIV9_MULT);

  always_comb begin
    num    = (NUMW'(d_p1_q) << 2) - NUMW'(d_p2_q);
    num_sh = num >> (GFB + 2);
    unique case (cfg_i.mode)
      MODE_BOX: begin
        res = d_q9_q;
      end
      MODE_LAPLACE: begin
        res = d_lap_q[LAPW-1] ? '0 : d_lap_q[PIX_W+1:2];
      end
      MODE_SHARPEN: begin
        if (num[NUMW-1]) begin
          res = '0;
        end else if (num_sh > NUMW'(255)) begin
          res = '1;
        end else begin
          res = num_sh[PIX_W-1:0];
        end
      end
      default: begin
        res = d_ctr_q;
      end
    endcase
  end

  assign res_push_o                = d_vld_q;
  assign res_item_o.filtered_value = res;
  assign res_item_o.frame_last     = d_last_q;

  always_ff @(posedge clk_i) begin
    if (mq_pop_o) begin
      a_base_q <= out_slot_q;
      a_mask_q <= mq_entry_i.mask;
      a_last_q <= mq_entry_i.last;
    end
    b_mask_q <= a_mask_q;
    b_last_q <= a_last_q;
    if (b_vld_q) begin
      lc_up_q  <= up_c_q;
      lc_mid_q <= mid_c_q;
      lc_dn_q  <= dn_c_q;
    end
    c_sum9_q <= sum9;
    c_sum4_q <= sum4;
    c_ctr_q  <= mid_c_q;
    c_last_q <= b_last_q;
    d_p1_q   <= P1W'(one_g) * P1W'(c_ctr_q);
    d_p2_q   <= P2W'(cfg_i.gain) * P2W'(c_sum4_q);
    d_q9_q   <= q9[DIV9_SHIFT +: PIX_W];
    d_lap_q  <= (LAPW'(c_ctr_q) << 2) - LAPW'(c_sum4_q);
    d_ctr_q  <= c_ctr_q;
    d_last_q <= c_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q  <= '0;
      out_slot_q <= '0;
      a_vld_q    <= 1'b0;
      b_vld_q    <= 1'b0;
      c_vld_q    <= 1'b0;
      d_vld_q    <= 1'b0;
    end else begin
      if (restart_i) begin
        wr_slot_q  <= '0;
        out_slot_q <= '0;
      end else begin
        if (mem_we) begin
          wr_slot_q <= wr_slot_q + 1'b1;
        end
        if (mq_pop_o && mq_entry_i.emit) begin
          out_slot_q <= out_slot_q + 1'b1;
        end
      end
      a_vld_q <= mq_pop_o && mq_entry_i.emit;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

endmodule

// File: rtl/conv3x3_mean_laplace_sharpen_unit.sv
// Top level of the 3x3 mean / Laplace / sharpen filter: APB register file,
// front end, front-to-back queue, back end and result queue. Uses c3ms_pkg.
//
// Takes one 8-bit gray pixel (or drain beat) per clock in raster order while
// the front queue is not full and returns at most one filtered pixel per
// beat, sustaining one beat per clock unless the result queue backs up. A
// result is due once the pixel one row and one pixel beyond its centre has
// arrived, or the frame is complete; drain beats flush the tail of a frame.
// Once due, a result passes a queue stage, a ring write, a registered read of
// six pixels from three rings of 2**clog2(2*MAX_WIDTH+4) entries, a sum stage
// and a multiply stage into the result queue. Neighbours outside the frame
// are dropped. Width and height are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT;
// writing either restarts the stream. Registers: 0 filter_mode, 1 sharpen_gain
// (Q4.8), 2 image_width, 3 image_height, at byte addresses 0, 4, 8, 12.
module conv3x3_mean_laplace_sharpen_unit #(
  parameter int MAX_WIDTH      = c3ms_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = c3ms_pkg::DEF_MAX_HEIGHT,
  parameter int GAIN_FRAC_BITS = c3ms_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [c3ms_pkg::CFG_AW-1:0]   paddr,
  input  logic [c3ms_pkg::CFG_DW-1:0]   pwdata,
  output logic [c3ms_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          push,
  input  c3ms_pkg::in_item_t            in_item_i,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output c3ms_pkg::out_item_t           out_item_o
);

  import c3ms_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);

  logic [MODE_W-1:0] mode_q;
  logic [GAIN_W-1:0] gain_q;
  logic [WREG_W-1:0] width_q;
  logic [HREG_W-1:0] height_q;
  logic [1:0]        reg_idx;
  logic              cfg_we, restart;
  logic [31:0]       w_clamp, h_clamp;
  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  cfg_t              cfg;

  logic      mq_push, mq_full, mq_pop, mq_empty;
  mq_entry_t mq_in, mq_out;
  logic      res_push, res_full;
  out_item_t res_item;
  logic [$clog2(RES_DEPTH+1)-1:0] res_count;
  logic [$clog2(MQ_DEPTH+1)-1:0]  mq_count;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;
  assign restart = cfg_we && ((reg_idx == REG_IMAGE_WIDTH) || (reg_idx == REG_IMAGE_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BOX;
      gain_q   <= GAIN_W'(256);
      width_q  <= WREG_W'(640);
      height_q <= HREG_W'(480);
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_FILTER_MODE:  mode_q   <= pwdata[MODE_W-1:0];
        REG_SHARPEN_GAIN: gain_q   <= pwdata[GAIN_W-1:0];
        REG_IMAGE_WIDTH:  width_q  <= pwdata[WREG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[HREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FILTER_MODE:  prdata = CFG_DW'(mode_q);
      REG_SHARPEN_GAIN: prdata = CFG_DW'(gain_q);
      REG_IMAGE_WIDTH:  prdata = CFG_DW'(width_q);
      REG_IMAGE_HEIGHT: prdata = CFG_DW'(height_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (width_q == '0) begin
      w_clamp = 32'd1;
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_clamp = 32'(MAX_WIDTH);
    end else begin
      w_clamp = 32'(width_q);
    end
    if (height_q == '0) begin
      h_clamp = 32'd1;
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_clamp = 32'(MAX_HEIGHT);
    end else begin
      h_clamp = 32'(height_q);
    end
  end

  assign w_eff    = w_clamp[WW-1:0];
  assign h_eff    = h_clamp[HW-1:0];
  assign cfg.mode = mode_q;
  assign cfg.gain = gain_q;
  assign full     = mq_full;

  c3ms_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .w_i        (w_eff),
    .h_i        (h_eff),
    .push_i     (push),
    .item_i     (in_item_i),
    .mq_full_i  (mq_full),
    .mq_push_o  (mq_push),
    .mq_entry_o (mq_in)
  );

  c3ms_fifo #(
    .T     (mq_entry_t),
    .DEPTH (MQ_DEPTH)
  ) u_mq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mq_push),
    .data_i  (mq_in),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .data_o  (mq_out),
    .empty_o (mq_empty),
    .count_o (mq_count)
  );

  c3ms_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .cfg_i       (cfg),
    .w_i         (w_eff),
    .mq_entry_i  (mq_out),
    .mq_empty_i  (mq_empty),
    .mq_pop_o    (mq_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_item_o  (res_item)
  );

  c3ms_fifo #(
    .T     (out_item_t),
    .DEPTH (RES_DEPTH)
  ) u_res (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty),
    .count_o (res_count)
  );

  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && res_full))
    else $error("top: result beat pushed into a full result queue");

  a_mq_count_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mq_count == '0) == mq_empty)
    else $error("top: front queue count disagrees with its empty flag");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("top: pready dropped");

endmodule
